[sv/infix_expression_evaluator_core_macros.svh]
// Assertion macros shared by the checker of the expression evaluator.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef INFIX_EXPRESSION_EVALUATOR_CORE_MACROS_SVH
`define INFIX_EXPRESSION_EVALUATOR_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IEE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IEE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/iee_pkg.sv]
// Shared constants, types and saturation helpers of the expression evaluator.
// No dependencies; used by iee_alu and infix_expression_evaluator_core.
package iee_pkg;

  localparam int STACK_DEPTH     = 16;
  localparam int FRAC_BITS       = 32;
  localparam int MAX_FRAC_DIGITS = 9;

  localparam int PTR_W    = $clog2(STACK_DEPTH);
  localparam int CNT_W    = $clog2(STACK_DEPTH + 1);
  localparam int INT_W    = 64 - FRAC_BITS;
  localparam int FDIG_W   = 40;
  localparam int DIV_ITER = 64 + FRAC_BITS;
  localparam int ITER_W   = $clog2(DIV_ITER + 1);

  localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;
  localparam logic [63:0] POS_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] DIV_MIN  =
    64'(((64'd1 << FRAC_BITS) + 64'd999999999) / 64'd1000000000);
  localparam logic [INT_W-1:0] INT_CAP = INT_W'(1) << (63 - FRAC_BITS);
  localparam logic [127:0] MUL_HALF = 128'd1 << (FRAC_BITS - 1);

  localparam logic [63:0] POW10 [16] = '{
    64'd1, 64'd10, 64'd100, 64'd1000, 64'd10000, 64'd100000, 64'd1000000,
    64'd10000000, 64'd100000000, 64'd1000000000, 64'd10000000000,
    64'd100000000000, 64'd1000000000000, 64'd10000000000000,
    64'd100000000000000, 64'd1000000000000000
  };

  typedef enum logic [2:0] {
    OP_LP  = 3'd0,
    OP_ADD = 3'd1,
    OP_SUB = 3'd2,
    OP_MUL = 3'd3,
    OP_DIV = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV,
    ALU_CONV
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic err;
  } alu_rsp_t;

  typedef struct packed {
    logic        err;
    logic [63:0] val;
  } sat_t;

  function automatic logic [1:0] prio(op_t op);
    case (op)
      OP_ADD, OP_SUB: prio = 2'd1;
      OP_MUL, OP_DIV: prio = 2'd2;
      default:        prio = 2'd0;
    endcase
  endfunction

  function automatic logic [63:0] mag_of(logic [63:0] v);
    mag_of = v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic sat_t from_mag(logic neg, logic [63:0] mag, logic ovf);
    sat_t s;
    if (neg) begin
      if (ovf || (mag > SIGN_BIT)) begin
        s.err = 1'b1;
        s.val = SIGN_BIT;
      end else begin
        s.err = 1'b0;
        s.val = 64'd0 - mag;
      end
    end else begin
      if (ovf || (mag > POS_MAX)) begin
        s.err = 1'b1;
        s.val = POS_MAX;
      end else begin
        s.err = 1'b0;
        s.val = mag;
      end
    end
    from_mag = s;
  endfunction

endpackage

[sv/iee_alu.sv]
// Shared arithmetic unit: signed fixed-point add, subtract, multi-cycle multiply
// and bit-serial divide, plus unsigned fraction conversion. Depends on iee_pkg.
module iee_alu (
  input  logic               clk,
  input  logic               rst_n,
  input  iee_pkg::alu_req_t  req,
  input  logic [63:0]        opa,
  input  logic [63:0]        opb,
  output iee_pkg::alu_rsp_t  rsp,
  output logic [63:0]        res
);

  typedef enum logic [2:0] {
    A_IDLE,
    A_MULP,
    A_MULA,
    A_DIV,
    A_RND,
    A_FIN
  } astate_t;

  astate_t                       state_r, state_nxt;
  iee_pkg::alu_op_t              op_r, op_nxt;
  logic                          neg_r, neg_nxt;
  logic [63:0]                   a_r, a_nxt;
  logic [63:0]                   b_r, b_nxt;
  logic [63:0]                   ma_r, ma_nxt;
  logic [63:0]                   mb_r, mb_nxt;
  logic [63:0]                   prod_r, prod_nxt;
  logic [127:0]                  acc_r, acc_nxt;
  logic [1:0]                    mc_r, mc_nxt;
  logic [iee_pkg::DIV_ITER-1:0]  dvd_r, dvd_nxt;
  logic [63:0]                   rem_r, rem_nxt;
  logic [63:0]                   q_r, q_nxt;
  logic                          ovf_r, ovf_nxt;
  logic                          small_r, small_nxt;
  logic [iee_pkg::ITER_W-1:0]    it_r, it_nxt;

  logic [63:0]   ma_in, mb_in;
  logic [31:0]   ah, bh;
  logic [6:0]    sh;
  logic [63:0]   rem_sh, q_sh, s;
  iee_pkg::sat_t sat;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    neg_nxt   = neg_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    ma_nxt    = ma_r;
    mb_nxt    = mb_r;
    prod_nxt  = prod_r;
    acc_nxt   = acc_r;
    mc_nxt    = mc_r;
    dvd_nxt   = dvd_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    ovf_nxt   = ovf_r;
    small_nxt = small_r;
    it_nxt    = it_r;
    rsp       = '0;
    res       = 64'd0;
    ma_in     = iee_pkg::mag_of(opa);
    mb_in     = iee_pkg::mag_of(opb);
    ah        = mc_r[0] ? ma_r[63:32] : ma_r[31:0];
    bh        = mc_r[1] ? mb_r[63:32] : mb_r[31:0];
    sh        = {mc_r[0] & mc_r[1], mc_r[0] ^ mc_r[1], 5'd0};
    rem_sh    = {rem_r[62:0], dvd_r[iee_pkg::DIV_ITER-1]};
    q_sh      = {q_r[62:0], 1'b0};
    s         = 64'd0;
    sat       = '0;

    unique case (state_r)
      A_IDLE: begin
        if (req.start) begin
          op_nxt    = req.op;
          neg_nxt   = opa[63] ^ opb[63];
          a_nxt     = opa;
          b_nxt     = opb;
          ma_nxt    = ma_in;
          mb_nxt    = mb_in;
          acc_nxt   = iee_pkg::MUL_HALF;
          mc_nxt    = 2'd0;
          dvd_nxt   = {ma_in, {iee_pkg::FRAC_BITS{1'b0}}};
          rem_nxt   = 64'd0;
          q_nxt     = 64'd0;
          ovf_nxt   = 1'b0;
          it_nxt    = iee_pkg::ITER_W'(iee_pkg::DIV_ITER);
          small_nxt = (req.op == iee_pkg::ALU_DIV) && (mb_in < iee_pkg::DIV_MIN);
          unique case (req.op)
            iee_pkg::ALU_MUL:  state_nxt = A_MULP;
            iee_pkg::ALU_DIV:  state_nxt = (mb_in < iee_pkg::DIV_MIN) ? A_FIN : A_DIV;
            iee_pkg::ALU_CONV: state_nxt = A_DIV;
            default:           state_nxt = A_FIN;
          endcase
        end
      end
      A_MULP: begin
        prod_nxt  = {32'd0, ah} * {32'd0, bh};
        state_nxt = A_MULA;
      end
      A_MULA: begin
        acc_nxt   = acc_r + ({64'd0, prod_r} << sh);
        mc_nxt    = mc_r + 2'd1;
        state_nxt = (mc_r == 2'd3) ? A_FIN : A_MULP;
      end
      A_DIV: begin
        if (q_r[63]) begin
          ovf_nxt = 1'b1;
        end
        if (rem_sh >= mb_r) begin
          rem_nxt = rem_sh - mb_r;
          q_nxt   = q_sh | 64'd1;
        end else begin
          rem_nxt = rem_sh;
          q_nxt   = q_sh;
        end
        dvd_nxt = dvd_r << 1;
        it_nxt  = it_r - iee_pkg::ITER_W'(1);
        if (it_r == iee_pkg::ITER_W'(1)) begin
          state_nxt = A_RND;
        end
      end
      A_RND: begin
        if (rem_r >= (mb_r - rem_r)) begin
          if (&q_r) begin
            ovf_nxt = 1'b1;
          end
          q_nxt = q_r + 64'd1;
        end
        state_nxt = A_FIN;
      end
      A_FIN: begin
        rsp.done  = 1'b1;
        state_nxt = A_IDLE;
        unique case (op_r)
          iee_pkg::ALU_ADD: begin
            s = a_r + b_r;
            if ((a_r[63] == b_r[63]) && (s[63] != a_r[63])) begin
              rsp.err = 1'b1;
              s = a_r[63] ? iee_pkg::SIGN_BIT : iee_pkg::POS_MAX;
            end
            res = s;
          end
          iee_pkg::ALU_SUB: begin
            s = a_r - b_r;
            if ((a_r[63] != b_r[63]) && (s[63] != a_r[63])) begin
              rsp.err = 1'b1;
              s = a_r[63] ? iee_pkg::SIGN_BIT : iee_pkg::POS_MAX;
            end
            res = s;
          end
          iee_pkg::ALU_MUL: begin
            sat = iee_pkg::from_mag(neg_r, acc_r[iee_pkg::FRAC_BITS+63:iee_pkg::FRAC_BITS],
                                    |acc_r[127:iee_pkg::FRAC_BITS+64]);
            rsp.err = sat.err;
            res     = sat.val;
          end
          iee_pkg::ALU_DIV: begin
            if (small_r) begin
              rsp.err = 1'b1;
              res     = 64'd0;
            end else begin
              sat     = iee_pkg::from_mag(neg_r, q_r, ovf_r);
              rsp.err = sat.err;
              res     = sat.val;
            end
          end
          default: begin
            res = q_r;
          end
        endcase
      end
      default: state_nxt = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    op_r    <= op_nxt;
    neg_r   <= neg_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    ma_r    <= ma_nxt;
    mb_r    <= mb_nxt;
    prod_r  <= prod_nxt;
    acc_r   <= acc_nxt;
    mc_r    <= mc_nxt;
    dvd_r   <= dvd_nxt;
    rem_r   <= rem_nxt;
    q_r     <= q_nxt;
    ovf_r   <= ovf_nxt;
    small_r <= small_nxt;
    it_r    <= it_nxt;
  end

endmodule

[sv/infix_expression_evaluator_core.sv]
// Character-serial infix expression evaluator with operator and operand stacks.
// A digit, dot or sign character passes S_CHAR and S_TAIL; an operator or
// parenthesis first closes any open number (a fraction division in the arithmetic
// unit), then runs each reduction through S_APPLY, S_POPB, S_POPA and S_ALU.
// Results are not stallable and leave via S_DONE and S_OUT after the last
// character; synchronous reset clears state, counts, flags and token, not stacks.
module infix_expression_evaluator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_char_code,
  input  logic        in_last_char,
  output logic        out_strobe,
  output logic [63:0] out_value,
  output logic        out_error
);

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;

  typedef enum logic [2:0] {
    CLS_START,
    CLS_NUM,
    CLS_OP,
    CLS_LP,
    CLS_RP,
    CLS_OTHER
  } cls_t;

  typedef enum logic [1:0] {
    AR_HOP,
    AR_RP,
    AR_FIN
  } aret_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHAR,
    S_CLOSE,
    S_CONV,
    S_ACT,
    S_HOP,
    S_HOP_R,
    S_RP,
    S_RP_R,
    S_FIN,
    S_FIN_R,
    S_APPLY,
    S_POPB,
    S_POPA,
    S_ALU,
    S_TAIL,
    S_DONE,
    S_OUT
  } state_t;

  state_t                          state_r, state_nxt;
  logic [7:0]                      char_r, char_nxt;
  logic                            last_r, last_nxt;
  logic [iee_pkg::CNT_W-1:0]       opnd_cnt_r, opnd_cnt_nxt;
  logic [iee_pkg::CNT_W-1:0]       opr_cnt_r, opr_cnt_nxt;
  logic [iee_pkg::INT_W-1:0]       int_r, int_nxt;
  logic [iee_pkg::FDIG_W-1:0]      frac_r, frac_nxt;
  logic [3:0]                      fcnt_r, fcnt_nxt;
  logic                            tok_open_r, tok_open_nxt;
  logic                            tok_neg_r, tok_neg_nxt;
  logic                            tok_dig_r, tok_dig_nxt;
  logic                            tok_dot_r, tok_dot_nxt;
  cls_t                            prev_r, prev_nxt;
  logic                            err_r, err_nxt;
  logic                            fin_r, fin_nxt;
  iee_pkg::op_t                    hop_op_r, hop_op_nxt;
  logic                            hop_to_act_r, hop_to_act_nxt;
  iee_pkg::op_t                    apply_op_r, apply_op_nxt;
  aret_t                           apply_ret_r, apply_ret_nxt;
  logic [63:0]                     b_r, b_nxt;
  logic                            out_strobe_r, out_strobe_nxt;
  logic [63:0]                     out_value_r, out_value_nxt;
  logic                            out_error_r, out_error_nxt;

  logic [63:0]                     opnd_mem [iee_pkg::STACK_DEPTH];
  iee_pkg::op_t                    opr_mem [iee_pkg::STACK_DEPTH];
  logic [63:0]                     opnd_q_r;
  iee_pkg::op_t                    opr_q_r;

  logic                            opnd_we, opr_we;
  logic [iee_pkg::PTR_W-1:0]       opnd_raddr;
  logic [63:0]                     opnd_wdata;
  iee_pkg::op_t                    opr_wdata;
  logic [iee_pkg::CNT_W-1:0]       opnd_m1, opnd_m2, opr_m1;

  logic                            push_opnd, push_opr, clear_tok;
  logic [63:0]                     push_val;
  iee_pkg::op_t                    push_code;

  logic                            is_digit, is_sign, is_dot, is_lpar;
  cls_t                            cls;
  iee_pkg::op_t                    char_op;
  logic [iee_pkg::INT_W+3:0]       int_ext;
  logic [iee_pkg::FDIG_W-1:0]      frac_ext;
  state_t                          hop_ret, apply_dest;
  iee_pkg::sat_t                   conv_sat;

  iee_pkg::alu_req_t               alu_req;
  iee_pkg::alu_rsp_t               alu_rsp;
  logic [63:0]                     alu_a, alu_b, alu_res;

  iee_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .opa   (alu_a),
    .opb   (alu_b),
    .rsp   (alu_rsp),
    .res   (alu_res)
  );

  function automatic iee_pkg::alu_op_t alu_code(iee_pkg::op_t op);
    case (op)
      iee_pkg::OP_ADD: alu_code = iee_pkg::ALU_ADD;
      iee_pkg::OP_SUB: alu_code = iee_pkg::ALU_SUB;
      iee_pkg::OP_MUL: alu_code = iee_pkg::ALU_MUL;
      default:         alu_code = iee_pkg::ALU_DIV;
    endcase
  endfunction

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_value  = out_value_r;
  assign out_error  = out_error_r;

  always_comb begin
    is_digit = (char_r >= CH_0) && (char_r <= CH_9);
    is_sign  = (char_r == CH_PLUS) || (char_r == CH_MINUS);
    is_dot   = (char_r == CH_DOT);
    is_lpar  = (char_r == CH_LPAR);
    if (is_digit || is_dot) begin
      cls = CLS_NUM;
    end else if (is_sign || (char_r == CH_STAR) || (char_r == CH_SLASH)) begin
      cls = CLS_OP;
    end else if (is_lpar) begin
      cls = CLS_LP;
    end else if (char_r == CH_RPAR) begin
      cls = CLS_RP;
    end else begin
      cls = CLS_OTHER;
    end
    if (char_r == CH_PLUS) begin
      char_op = iee_pkg::OP_ADD;
    end else if (char_r == CH_MINUS) begin
      char_op = iee_pkg::OP_SUB;
    end else if (char_r == CH_STAR) begin
      char_op = iee_pkg::OP_MUL;
    end else begin
      char_op = iee_pkg::OP_DIV;
    end
    int_ext  = ({4'd0, int_r} << 3) + ({4'd0, int_r} << 1)
             + (iee_pkg::INT_W+4)'(char_r[3:0]);
    frac_ext = (frac_r << 3) + (frac_r << 1) + iee_pkg::FDIG_W'(char_r[3:0]);
    opnd_m1  = opnd_cnt_r - iee_pkg::CNT_W'(1);
    opnd_m2  = opnd_cnt_r - iee_pkg::CNT_W'(2);
    opr_m1   = opr_cnt_r - iee_pkg::CNT_W'(1);
    hop_ret  = hop_to_act_r ? S_ACT : S_TAIL;
    unique case (apply_ret_r)
      AR_HOP:  apply_dest = S_HOP;
      AR_RP:   apply_dest = S_RP;
      AR_FIN:  apply_dest = S_FIN;
      default: apply_dest = S_FIN;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    char_nxt       = char_r;
    last_nxt       = last_r;
    opnd_cnt_nxt   = opnd_cnt_r;
    opr_cnt_nxt    = opr_cnt_r;
    int_nxt        = int_r;
    frac_nxt       = frac_r;
    fcnt_nxt       = fcnt_r;
    tok_open_nxt   = tok_open_r;
    tok_neg_nxt    = tok_neg_r;
    tok_dig_nxt    = tok_dig_r;
    tok_dot_nxt    = tok_dot_r;
    prev_nxt       = prev_r;
    err_nxt        = err_r;
    fin_nxt        = fin_r;
    hop_op_nxt     = hop_op_r;
    hop_to_act_nxt = hop_to_act_r;
    apply_op_nxt   = apply_op_r;
    apply_ret_nxt  = apply_ret_r;
    b_nxt          = b_r;
    out_strobe_nxt = 1'b0;
    out_value_nxt  = out_value_r;
    out_error_nxt  = out_error_r;
    opnd_raddr     = opnd_m1[iee_pkg::PTR_W-1:0];
    push_opnd      = 1'b0;
    push_val       = alu_res;
    push_opr       = 1'b0;
    push_code      = hop_op_r;
    clear_tok      = 1'b0;
    alu_req        = '0;
    alu_a          = 64'd0;
    alu_b          = 64'd0;
    conv_sat       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          char_nxt  = in_char_code;
          last_nxt  = in_last_char;
          state_nxt = S_CHAR;
        end
      end
      S_CHAR: begin
        state_nxt = S_TAIL;
        if (!err_r) begin
          prev_nxt = cls;
          if ((prev_r == CLS_START) && !(is_digit || is_sign || is_lpar)) begin
            err_nxt = 1'b1;
          end else if (is_sign && ((prev_r == CLS_START) || (prev_r == CLS_OP) ||
                                   (prev_r == CLS_LP))) begin
            if (tok_open_r) begin
              err_nxt = 1'b1;
            end else begin
              tok_open_nxt = 1'b1;
              tok_neg_nxt  = (char_r == CH_MINUS);
            end
          end else if (is_digit) begin
            tok_open_nxt = 1'b1;
            tok_dig_nxt  = 1'b1;
            if (tok_dot_r) begin
              if (fcnt_r < 4'(iee_pkg::MAX_FRAC_DIGITS)) begin
                frac_nxt = frac_ext;
                fcnt_nxt = fcnt_r + 4'd1;
              end
            end else if (int_ext > {4'd0, iee_pkg::INT_CAP}) begin
              int_nxt = iee_pkg::INT_CAP;
              err_nxt = 1'b1;
            end else begin
              int_nxt = int_ext[iee_pkg::INT_W-1:0];
            end
          end else if (is_dot) begin
            if (tok_dot_r) begin
              err_nxt = 1'b1;
            end else begin
              tok_open_nxt = 1'b1;
              tok_dot_nxt  = 1'b1;
            end
          end else begin
            fin_nxt   = 1'b0;
            state_nxt = S_CLOSE;
          end
        end
      end
      S_CLOSE: begin
        if (!tok_open_r) begin
          state_nxt = S_ACT;
        end else if (!tok_dig_r && !tok_dot_r) begin
          clear_tok      = 1'b1;
          hop_op_nxt     = tok_neg_r ? iee_pkg::OP_SUB : iee_pkg::OP_ADD;
          hop_to_act_nxt = 1'b1;
          state_nxt      = S_HOP;
        end else if (!tok_dig_r) begin
          clear_tok = 1'b1;
          err_nxt   = 1'b1;
          state_nxt = S_ACT;
        end else begin
          alu_req.start = 1'b1;
          alu_req.op    = iee_pkg::ALU_CONV;
          alu_a         = 64'(frac_r);
          alu_b         = iee_pkg::POW10[fcnt_r];
          state_nxt     = S_CONV;
        end
      end
      S_CONV: begin
        if (alu_rsp.done) begin
          conv_sat  = iee_pkg::from_mag(tok_neg_r,
                        {int_r, {iee_pkg::FRAC_BITS{1'b0}}} + alu_res, 1'b0);
          push_opnd = 1'b1;
          push_val  = conv_sat.val;
          if (conv_sat.err) begin
            err_nxt = 1'b1;
          end
          clear_tok = 1'b1;
          state_nxt = S_ACT;
        end
      end
      S_ACT: begin
        if (fin_r) begin
          state_nxt = S_FIN;
        end else if (err_r) begin
          state_nxt = S_TAIL;
        end else begin
          case (cls)
            CLS_OP: begin
              hop_op_nxt     = char_op;
              hop_to_act_nxt = 1'b0;
              state_nxt      = S_HOP;
            end
            CLS_LP: begin
              push_opr  = 1'b1;
              push_code = iee_pkg::OP_LP;
              state_nxt = S_TAIL;
            end
            CLS_RP: begin
              state_nxt = S_RP;
            end
            default: begin
              err_nxt   = 1'b1;
              state_nxt = S_TAIL;
            end
          endcase
        end
      end
      S_HOP: begin
        if (err_r) begin
          state_nxt = hop_ret;
        end else if (opr_cnt_r != '0) begin
          state_nxt = S_HOP_R;
        end else begin
          push_opr  = 1'b1;
          state_nxt = hop_ret;
        end
      end
      S_HOP_R: begin
        if (iee_pkg::prio(opr_q_r) >= iee_pkg::prio(hop_op_r)) begin
          opr_cnt_nxt   = opr_m1;
          apply_op_nxt  = opr_q_r;
          apply_ret_nxt = AR_HOP;
          state_nxt     = S_APPLY;
        end else begin
          push_opr  = 1'b1;
          state_nxt = hop_ret;
        end
      end
      S_RP: begin
        if (err_r) begin
          state_nxt = S_TAIL;
        end else if (opr_cnt_r == '0) begin
          err_nxt   = 1'b1;
          state_nxt = S_TAIL;
        end else begin
          state_nxt = S_RP_R;
        end
      end
      S_RP_R: begin
        opr_cnt_nxt = opr_m1;
        if (opr_q_r != iee_pkg::OP_LP) begin
          apply_op_nxt  = opr_q_r;
          apply_ret_nxt = AR_RP;
          state_nxt     = S_APPLY;
        end else begin
          state_nxt = S_TAIL;
        end
      end
      S_FIN: begin
        if (err_r) begin
          state_nxt = S_DONE;
        end else if (opr_cnt_r == '0) begin
          if (opnd_cnt_r != iee_pkg::CNT_W'(1)) begin
            err_nxt = 1'b1;
          end
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_FIN_R;
        end
      end
      S_FIN_R: begin
        opr_cnt_nxt = opr_m1;
        if (opr_q_r == iee_pkg::OP_LP) begin
          err_nxt   = 1'b1;
          state_nxt = S_FIN;
        end else begin
          apply_op_nxt  = opr_q_r;
          apply_ret_nxt = AR_FIN;
          state_nxt     = S_APPLY;
        end
      end
      S_APPLY: begin
        if (opnd_cnt_r < iee_pkg::CNT_W'(2)) begin
          err_nxt   = 1'b1;
          state_nxt = apply_dest;
        end else begin
          state_nxt = S_POPB;
        end
      end
      S_POPB: begin
        b_nxt      = opnd_q_r;
        opnd_raddr = opnd_m2[iee_pkg::PTR_W-1:0];
        state_nxt  = S_POPA;
      end
      S_POPA: begin
        alu_req.start = 1'b1;
        alu_req.op    = alu_code(apply_op_r);
        alu_a         = opnd_q_r;
        alu_b         = b_r;
        opnd_cnt_nxt  = opnd_m2;
        state_nxt     = S_ALU;
      end
      S_ALU: begin
        if (alu_rsp.done) begin
          push_opnd = 1'b1;
          if (alu_rsp.err) begin
            err_nxt = 1'b1;
          end
          state_nxt = apply_dest;
        end
      end
      S_TAIL: begin
        if (!last_r) begin
          state_nxt = S_IDLE;
        end else if (err_r) begin
          state_nxt = S_DONE;
        end else begin
          fin_nxt   = 1'b1;
          state_nxt = S_CLOSE;
        end
      end
      S_DONE: begin
        opnd_raddr = '0;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        out_strobe_nxt = 1'b1;
        out_value_nxt  = err_r ? 64'd0 : opnd_q_r;
        out_error_nxt  = err_r;
        opnd_cnt_nxt   = '0;
        opr_cnt_nxt    = '0;
        clear_tok      = 1'b1;
        prev_nxt       = CLS_START;
        err_nxt        = 1'b0;
        fin_nxt        = 1'b0;
        state_nxt      = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    opnd_we    = 1'b0;
    opnd_wdata = push_val;
    if (push_opnd) begin
      if (opnd_cnt_r >= iee_pkg::CNT_W'(iee_pkg::STACK_DEPTH)) begin
        err_nxt = 1'b1;
      end else begin
        opnd_we      = 1'b1;
        opnd_cnt_nxt = opnd_cnt_r + iee_pkg::CNT_W'(1);
      end
    end
    opr_we    = 1'b0;
    opr_wdata = push_code;
    if (push_opr) begin
      if (opr_cnt_r >= iee_pkg::CNT_W'(iee_pkg::STACK_DEPTH)) begin
        err_nxt = 1'b1;
      end else begin
        opr_we      = 1'b1;
        opr_cnt_nxt = opr_cnt_r + iee_pkg::CNT_W'(1);
      end
    end
    if (clear_tok) begin
      tok_open_nxt = 1'b0;
      tok_neg_nxt  = 1'b0;
      tok_dig_nxt  = 1'b0;
      tok_dot_nxt  = 1'b0;
      int_nxt      = '0;
      frac_nxt     = '0;
      fcnt_nxt     = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (opnd_we) begin
      opnd_mem[opnd_cnt_r[iee_pkg::PTR_W-1:0]] <= opnd_wdata;
    end
    opnd_q_r <= opnd_mem[opnd_raddr];
  end

  always_ff @(posedge clk) begin
    if (opr_we) begin
      opr_mem[opr_cnt_r[iee_pkg::PTR_W-1:0]] <= opr_wdata;
    end
    opr_q_r <= opr_mem[opr_m1[iee_pkg::PTR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      opnd_cnt_r   <= '0;
      opr_cnt_r    <= '0;
      int_r        <= '0;
      frac_r       <= '0;
      fcnt_r       <= 4'd0;
      tok_open_r   <= 1'b0;
      tok_neg_r    <= 1'b0;
      tok_dig_r    <= 1'b0;
      tok_dot_r    <= 1'b0;
      prev_r       <= CLS_START;
      err_r        <= 1'b0;
      fin_r        <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      opnd_cnt_r   <= opnd_cnt_nxt;
      opr_cnt_r    <= opr_cnt_nxt;
      int_r        <= int_nxt;
      frac_r       <= frac_nxt;
      fcnt_r       <= fcnt_nxt;
      tok_open_r   <= tok_open_nxt;
      tok_neg_r    <= tok_neg_nxt;
      tok_dig_r    <= tok_dig_nxt;
      tok_dot_r    <= tok_dot_nxt;
      prev_r       <= prev_nxt;
      err_r        <= err_nxt;
      fin_r        <= fin_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
    char_r       <= char_nxt;
    last_r       <= last_nxt;
    hop_op_r     <= hop_op_nxt;
    hop_to_act_r <= hop_to_act_nxt;
    apply_op_r   <= apply_op_nxt;
    apply_ret_r  <= apply_ret_nxt;
    b_r          <= b_nxt;
    out_value_r  <= out_value_nxt;
    out_error_r  <= out_error_nxt;
  end

endmodule

[sv/iee_checker.sv]
// Port-level checker of the expression evaluator and its bind statement.
// Depends on infix_expression_evaluator_core_macros.svh.
`include "infix_expression_evaluator_core_macros.svh"

module iee_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_strobe,
  input logic [63:0] out_value,
  input logic        out_error
);

  `IEE_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
  `IEE_ASSERT_NEXT(a_strobe_pulse, out_strobe, !out_strobe, "result strobe longer than one cycle")
  `IEE_ASSERT_SAME(a_error_zero, out_strobe && out_error, out_value == 64'd0, "error result not zero")
  `IEE_ASSERT_SAME(a_strobe_after_work, out_strobe, $past(busy), "result without preceding work")

endmodule

bind infix_expression_evaluator_core iee_checker u_iee_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_value  (out_value),
  .out_error  (out_error)
);

[bench/tb_infix_expression_evaluator_core.sv]
// Self-checking testbench for infix_expression_evaluator_core: sends expressions one
// character per transaction and compares each result with a built-in evaluator.
// Depends on iee_pkg and the RTL of infix_expression_evaluator_core.
`timescale 1ns / 100ps

module tb_infix_expression_evaluator_core;

  typedef enum logic [2:0] {
    CL_START, CL_NUM, CL_OP, CL_LP, CL_RP, CL_OTHER
  } char_class_t;

  typedef struct {
    logic [63:0] value;
    logic        error;
  } eval_result_t;

  localparam logic [3:0] TOK_OPEN  = 4'b0001;
  localparam logic [3:0] TOK_NEG   = 4'b0010;
  localparam logic [3:0] TOK_DIGIT = 4'b0100;
  localparam logic [3:0] TOK_DOT   = 4'b1000;

  localparam int ITEM_TARGET = 1950;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [7:0]  in_char_code;
  logic        in_last_char;
  logic        out_strobe;
  logic [63:0] out_value;
  logic        out_error;

  eval_result_t pending_results[$];
  int           fail_count;
  int           chars_sent;
  bit           gaps_on;
  byte          expr_chars[$];

  logic [63:0]  val_stack[16];
  int           val_count;
  iee_pkg::op_t op_stack[16];
  int           op_count;
  logic [63:0]  int_digits;
  logic [63:0]  frac_digits;
  int           frac_count;
  logic [3:0]   tok;
  char_class_t  prev_class;
  logic         expr_err;

  infix_expression_evaluator_core uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_char_code(in_char_code), .in_last_char(in_last_char),
    .out_strobe(out_strobe), .out_value(out_value), .out_error(out_error)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic int rank(iee_pkg::op_t op);
    if (op == iee_pkg::OP_ADD || op == iee_pkg::OP_SUB) return 1;
    if (op == iee_pkg::OP_MUL || op == iee_pkg::OP_DIV) return 2;
    return 0;
  endfunction

  function automatic logic [63:0] abs64(logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic logic [63:0] saturate(logic neg, logic [63:0] mag, logic ovf);
    if (neg) begin
      if (ovf || mag > iee_pkg::SIGN_BIT) begin
        expr_err = 1'b1;
        return iee_pkg::SIGN_BIT;
      end
      return 64'd0 - mag;
    end
    if (ovf || mag > iee_pkg::POS_MAX) begin
      expr_err = 1'b1;
      return iee_pkg::POS_MAX;
    end
    return mag;
  endfunction

  function automatic void push_value(logic [63:0] v);
    if (val_count >= 16) begin
      expr_err = 1'b1;
      return;
    end
    val_stack[val_count] = v;
    val_count++;
  endfunction

  function automatic void push_op(iee_pkg::op_t op);
    if (op_count >= 16) begin
      expr_err = 1'b1;
      return;
    end
    op_stack[op_count] = op;
    op_count++;
  endfunction

  function automatic logic [63:0] fixed_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, abs64(a)} * {64'd0, abs64(b)};
    p = p + (128'd1 << 31);
    return saturate(a[63] ^ b[63], p[95:32], p[127:96] != 0);
  endfunction

  function automatic logic [63:0] fixed_div(logic [63:0] a, logic [63:0] b);
    logic [63:0] ma, d, q, r;
    logic ovf, nb;
    ma = abs64(a);
    d = abs64(b);
    q = 0;
    r = 0;
    ovf = 0;
    if (d < 64'd5) begin
      expr_err = 1'b1;
      return 64'd0;
    end
    for (int i = 95; i >= 0; i--) begin
      nb = (i >= 32) ? ma[i-32] : 1'b0;
      r = {r[62:0], nb};
      if (q[63]) ovf = 1'b1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q[0] = 1'b1;
      end
    end
    if (r >= d - r) begin
      if (q == '1) ovf = 1'b1;
      q = q + 1;
    end
    return saturate(a[63] ^ b[63], q, ovf);
  endfunction

  function automatic void apply_op(iee_pkg::op_t op);
    logic [63:0] a, b, s;
    if (val_count < 2) begin
      expr_err = 1'b1;
      return;
    end
    val_count--;
    b = val_stack[val_count];
    val_count--;
    a = val_stack[val_count];
    case (op)
      iee_pkg::OP_ADD: begin
        s = a + b;
        if (!(a[63] ^ b[63]) && (s[63] ^ a[63])) begin
          expr_err = 1'b1;
          s = a[63] ? iee_pkg::SIGN_BIT : iee_pkg::POS_MAX;
        end
      end
      iee_pkg::OP_SUB: begin
        s = a - b;
        if ((a[63] ^ b[63]) && (s[63] ^ a[63])) begin
          expr_err = 1'b1;
          s = a[63] ? iee_pkg::SIGN_BIT : iee_pkg::POS_MAX;
        end
      end
      iee_pkg::OP_MUL: s = fixed_mul(a, b);
      default: s = fixed_div(a, b);
    endcase
    push_value(s);
  endfunction

  function automatic void reduce_and_push(iee_pkg::op_t op);
    while (!expr_err && op_count > 0 && rank(op_stack[op_count-1]) >= rank(op)) begin
      op_count--;
      apply_op(op_stack[op_count]);
    end
    if (!expr_err) push_op(op);
  endfunction

  function automatic void clear_number();
    tok = 0;
    int_digits = 0;
    frac_digits = 0;
    frac_count = 0;
  endfunction

  function automatic void close_number();
    logic [3:0] f;
    logic [63:0] p, r, q;
    f = tok;
    if (!(f & TOK_OPEN)) return;
    if (!(f & (TOK_DIGIT | TOK_DOT))) begin
      clear_number();
      reduce_and_push((f & TOK_NEG) ? iee_pkg::OP_SUB : iee_pkg::OP_ADD);
      return;
    end
    if (!(f & TOK_DIGIT)) begin
      clear_number();
      expr_err = 1'b1;
      return;
    end
    p = 1;
    r = frac_digits;
    q = 0;
    repeat (frac_count) p = p * 10;
    repeat (32) begin
      r = r << 1;
      q = q << 1;
      if (r >= p) begin
        r = r - p;
        q[0] = 1'b1;
      end
    end
    if (r >= p - r) q = q + 1;
    q = (int_digits << 32) + q;
    clear_number();
    push_value(saturate((f & TOK_NEG) != 0, q, 1'b0));
  endfunction

  function automatic void eval_char(byte unsigned c);
    char_class_t pc, cls;
    logic is_sign, is_digit;
    pc = prev_class;
    is_sign = (c == "+" || c == "-");
    is_digit = (c >= "0" && c <= "9");
    if (is_digit || c == ".") cls = CL_NUM;
    else if (is_sign || c == "*" || c == "/") cls = CL_OP;
    else if (c == "(") cls = CL_LP;
    else if (c == ")") cls = CL_RP;
    else cls = CL_OTHER;
    prev_class = cls;
    if (pc == CL_START && !(is_digit || is_sign || c == "(")) begin
      expr_err = 1'b1;
      return;
    end
    if (is_sign && (pc == CL_START || pc == CL_OP || pc == CL_LP)) begin
      if (tok & TOK_OPEN) begin
        expr_err = 1'b1;
        return;
      end
      tok = TOK_OPEN | ((c == "-") ? TOK_NEG : 4'b0);
      return;
    end
    if (is_digit) begin
      tok = tok | TOK_OPEN | TOK_DIGIT;
      if (tok & TOK_DOT) begin
        if (frac_count < 9) begin
          frac_digits = frac_digits * 10 + (c - "0");
          frac_count++;
        end
      end else begin
        int_digits = int_digits * 10 + (c - "0");
        if (int_digits > (64'd1 << 31)) begin
          int_digits = 64'd1 << 31;
          expr_err = 1'b1;
        end
      end
      return;
    end
    if (c == ".") begin
      if (tok & TOK_DOT) begin
        expr_err = 1'b1;
        return;
      end
      tok = tok | TOK_OPEN | TOK_DOT;
      return;
    end
    close_number();
    if (expr_err) return;
    case (cls)
      CL_OP: reduce_and_push(c == "+" ? iee_pkg::OP_ADD : c == "-" ? iee_pkg::OP_SUB :
                             c == "*" ? iee_pkg::OP_MUL : iee_pkg::OP_DIV);
      CL_LP: push_op(iee_pkg::OP_LP);
      CL_RP: begin
        while (!expr_err && op_count > 0 && op_stack[op_count-1] != iee_pkg::OP_LP) begin
          op_count--;
          apply_op(op_stack[op_count]);
        end
        if (expr_err) return;
        if (op_count == 0) expr_err = 1'b1;
        else op_count--;
      end
      default: expr_err = 1'b1;
    endcase
  endfunction

  function automatic void clear_evaluator();
    val_count = 0;
    op_count = 0;
    clear_number();
    prev_class = CL_START;
    expr_err = 1'b0;
  endfunction

  function automatic void evaluate_char(byte unsigned c, logic last);
    eval_result_t res;
    iee_pkg::op_t op;
    if (!expr_err) eval_char(c);
    if (!last) return;
    if (!expr_err) begin
      close_number();
      while (!expr_err && op_count > 0) begin
        op_count--;
        op = op_stack[op_count];
        if (op == iee_pkg::OP_LP) expr_err = 1'b1;
        else apply_op(op);
      end
      if (val_count != 1) expr_err = 1'b1;
    end
    res.error = expr_err;
    res.value = expr_err ? 64'd0 : val_stack[0];
    pending_results.push_back(res);
    clear_evaluator();
  endfunction

  always @(posedge clk) begin
    eval_result_t exp_res;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        $error("result with no expected transaction: value %h error %b",
               out_value, out_error);
        fail_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_value !== exp_res.value) begin
          $error("value: expected %h, actual %h", exp_res.value, out_value);
          fail_count++;
        end
        if (out_error !== exp_res.error) begin
          $error("error: expected %b, actual %b", exp_res.error, out_error);
          fail_count++;
        end
      end
    end
  end

  task automatic send_char(byte unsigned c, logic last);
    logic was_busy;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    start <= 1'b1;
    in_char_code <= c;
    in_last_char <= last;
    do begin
      @(negedge clk);
      was_busy = busy;
      @(posedge clk);
    end while (was_busy);
    evaluate_char(c, last);
    chars_sent++;
  endtask

  task automatic send_chars();
    foreach (expr_chars[i]) send_char(expr_chars[i], i == expr_chars.size() - 1);
    expr_chars.delete();
  endtask

  task automatic send_string(string s);
    for (int i = 0; i < s.len(); i++) expr_chars.push_back(s[i]);
    send_chars();
  endtask

  task automatic gen_number();
    int n;
    if ($urandom_range(0, 4) == 0) expr_chars.push_back($urandom_range(0, 1) ? "-" : "+");
    if ($urandom_range(0, 19) == 0) begin
      expr_chars.push_back("0");
      return;
    end
    case ($urandom_range(0, 9))
      0: n = $urandom_range(9, 11);
      1, 2: n = $urandom_range(3, 6);
      3: n = 0;
      default: n = $urandom_range(1, 2);
    endcase
    repeat (n) expr_chars.push_back(8'("0" + $urandom_range(0, 9)));
    if (n == 0 || $urandom_range(0, 2) == 0) begin
      expr_chars.push_back(".");
      n = (n == 0) ? $urandom_range(1, 12) : $urandom_range(0, 12);
      repeat (n) expr_chars.push_back(8'("0" + $urandom_range(0, 9)));
    end
  endtask

  task automatic gen_expression(int depth);
    int terms;
    terms = $urandom_range(1, 4);
    for (int t = 0; t < terms; t++) begin
      if (t > 0) begin
        case ($urandom_range(0, 3))
          0: expr_chars.push_back("+");
          1: expr_chars.push_back("-");
          2: expr_chars.push_back("*");
          default: expr_chars.push_back("/");
        endcase
      end
      if (depth < 3 && $urandom_range(0, 3) == 0) begin
        expr_chars.push_back("(");
        gen_expression(depth + 1);
        expr_chars.push_back(")");
      end else begin
        gen_number();
      end
    end
  endtask

  task automatic test_arithmetic();
    send_string("1+2*3");
    send_string("-4.5/(2-0.25)");
    send_string("7-3-2");
    send_string("8/4/2*3");
    send_string("0.1234567891234*.5");
    send_string("-2147483648");
  endtask

  task automatic test_errors();
    send_string("*1");
    send_string("1 ");
    send_string("1..2");
    send_string(".");
    send_string("+-1");
    send_string("1/0.0000000001");
    send_string("2147483648");
    send_string("99999999999");
    send_string(")");
    send_string("(1");
    send_string("1)");
    send_string("1+");
    send_string("2*(-(3))");
    send_string("65536*65536");
    send_string("((((((((((((((((1))))))))))))))))");
  endtask

  task automatic test_extreme_codes();
    send_char(8'hFF, 1'b1);
    send_char(8'h00, 1'b1);
    send_char("5", 1'b0);
    send_char(8'h80, 1'b0);
    send_char("(", 1'b1);
  endtask

  task automatic test_random_expressions();
    int kind, pos;
    gaps_on = 1'b1;
    while (chars_sent < ITEM_TARGET) begin
      if (chars_sent > ITEM_TARGET * 85 / 100) gaps_on = 1'b0;
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        repeat ($urandom_range(1, 6)) expr_chars.push_back(8'($urandom_range(0, 255)));
      end else begin
        gen_expression(0);
        if (kind == 1) begin
          pos = $urandom_range(0, expr_chars.size() - 1);
          if ($urandom_range(0, 1)) expr_chars.delete(pos);
          else expr_chars.insert(pos, 8'($urandom_range(0, 255)));
          if (expr_chars.size() == 0) expr_chars.push_back("1");
        end
      end
      send_chars();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_char_code = 8'd0;
    in_last_char = 1'b0;
    fail_count = 0;
    chars_sent = 0;
    gaps_on = 1'b0;
    clear_evaluator();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_arithmetic();
    test_errors();
    test_extreme_codes();
    test_random_expressions();
    start <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
